[src/brt_pkg.sv]
`timescale 1ns / 1ps

package brt_pkg;

    // Nanoseconds in one second, the fixed divisor of the conversion.
    localparam int unsigned NS_PER_SEC_INT = 1000000000;
    localparam logic [29:0] NS_PER_SEC     = 30'(NS_PER_SEC_INT);

    // Field widths.
    localparam int RATE_W  = 64;
    localparam int TIME_W  = 64;
    localparam int BYTES_W = 64;
    localparam int PROD_W  = 127;

    // Radix-16 long division: one quotient digit per stage.
    localparam int DIGIT_W    = 4;
    localparam int DIV_STAGES = BYTES_W / DIGIT_W;
    localparam int DIGITS     = 2 ** DIGIT_W;
    localparam int CUR_W      = 30 + DIGIT_W;

    // Largest product rate*time whose rounded-up quotient still fits in 64 bits.
    localparam logic [PROD_W-1:0] PROD_MAX =
        ((PROD_W'(1) << BYTES_W) * PROD_W'(NS_PER_SEC_INT)) - PROD_W'(NS_PER_SEC_INT);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Multiple of the divisor for one quotient digit.
    function automatic logic [CUR_W-1:0] div_mult(input logic [DIGIT_W-1:0] k);
        return CUR_W'(k) * CUR_W'(NS_PER_SEC);
    endfunction

endpackage

[src/bytes_for_residence_time.sv]
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                     tuser        tlast
// s_axis    in         rate[63:0], residence_ns[127:64]       -            -
// m_axis    out        bytes[63:0]                            status[1:0]  -
//
// One transfer is accepted per cycle while the output side does not stall. The pipeline
// has four stages that form the 127-bit product, one range check, and sixteen
// radix-16 division stages by 1e9, followed by an output register.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.

module bytes_for_residence_time
    import brt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // rate[63:0], residence_ns[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // bytes[63:0]
    output logic [1:0]   m_axis_tuser    // status[1:0]
);

    logic                advance;
    logic [RATE_W-1:0]   in_rate;
    logic [TIME_W-1:0]   in_time;
    status_t             in_status;

    // Stage 1: partial products.
    logic                st1_valid_reg;
    status_t             st1_status_reg;
    logic [63:0]         p00_reg;
    logic [62:0]         p01_reg;
    logic [63:0]         p10_reg;
    logic [62:0]         p11_reg;

    // Stage 2: cross terms summed.
    logic                st2_valid_reg;
    status_t             st2_status_reg;
    logic [63:0]         lo2_reg;
    logic [64:0]         mid2_reg;
    logic [62:0]         hi2_reg;

    // Stage 3: low half of the product.
    logic                st3_valid_reg;
    status_t             st3_status_reg;
    logic [63:0]         plo3_reg;
    logic                carry3_reg;
    logic [62:0]         hi3_reg;
    logic [32:0]         midhi3_reg;
    logic [64:0]         low_sum;

    // Stage 4: high half of the product.
    logic                st4_valid_reg;
    status_t             st4_status_reg;
    logic [63:0]         plo4_reg;
    logic [62:0]         phi4_reg;
    status_t             dv0_status_next;

    // Division stages; entry 0 holds the checked product.
    logic                dv_valid_reg  [0:DIV_STAGES];
    status_t             dv_status_reg [0:DIV_STAGES];
    logic [29:0]         dv_rem_reg    [0:DIV_STAGES];
    logic [BYTES_W-1:0]  dv_work_reg   [0:DIV_STAGES];

    // Output register.
    logic                m_valid_reg;
    logic [BYTES_W-1:0]  m_bytes_reg;
    status_t             m_status_reg;
    logic [BYTES_W-1:0]  m_bytes_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    assign in_rate = s_axis_tdata[63:0];
    assign in_time = s_axis_tdata[127:64];

    // A zero rate or a time that is zero or negative is rejected up front.
    always_comb begin
        if (in_rate == '0 || in_time == '0 || in_time[TIME_W-1]) begin
            in_status = ST_INVALID;
        end else begin
            in_status = ST_OK;
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            st1_valid_reg <= s_axis_tvalid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            dv_valid_reg[0] <= st4_valid_reg;
        end
    end

    // The 64 by 63 bit product is built from four 32-bit partial products.
    assign low_sum = 65'(lo2_reg) + 65'({mid2_reg[31:0], 32'd0});

    // Flag products whose rounded-up quotient would not fit in 64 bits.
    always_comb begin
        if (st4_status_reg == ST_OK && {phi4_reg, plo4_reg} > PROD_MAX) begin
            dv0_status_next = ST_RANGE;
        end else begin
            dv0_status_next = st4_status_reg;
        end
    end

    // Data of the front stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_status_reg <= in_status;
            p00_reg <= 64'(in_rate[31:0])  * 64'(in_time[31:0]);
            p01_reg <= 63'(in_rate[31:0])  * 63'(in_time[62:32]);
            p10_reg <= 64'(in_rate[63:32]) * 64'(in_time[31:0]);
            p11_reg <= 63'(in_rate[63:32]) * 63'(in_time[62:32]);

            st2_status_reg <= st1_status_reg;
            lo2_reg  <= p00_reg;
            mid2_reg <= 65'(p01_reg) + 65'(p10_reg);
            hi2_reg  <= p11_reg;

            st3_status_reg <= st2_status_reg;
            plo3_reg   <= low_sum[63:0];
            carry3_reg <= low_sum[64];
            hi3_reg    <= hi2_reg;
            midhi3_reg <= mid2_reg[64:32];

            st4_status_reg <= st3_status_reg;
            plo4_reg <= plo3_reg;
            phi4_reg <= hi3_reg + 63'(midhi3_reg) + 63'(carry3_reg);

            // The high bits seed the remainder; they are below 1e9 unless out of range.
            dv_status_reg[0] <= dv0_status_next;
            dv_rem_reg[0]    <= phi4_reg[29:0];
            dv_work_reg[0]   <= plo4_reg;
        end
    end

    // Each stage takes the next four product bits and yields one quotient digit.
    for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
        logic [CUR_W-1:0]   cur;
        logic [DIGIT_W-1:0] digit;

        always_comb begin
            cur   = {dv_rem_reg[gi], dv_work_reg[gi][BYTES_W-1 -: DIGIT_W]};
            digit = '0;
            for (int k = 1; k < DIGITS; k++) begin
                if (cur >= div_mult(DIGIT_W'(k))) begin
                    digit = DIGIT_W'(k);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[gi+1] <= 1'b0;
            end else if (advance) begin
                dv_valid_reg[gi+1] <= dv_valid_reg[gi];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                dv_status_reg[gi+1] <= dv_status_reg[gi];
                dv_rem_reg[gi+1]    <= 30'(cur - div_mult(digit));
                dv_work_reg[gi+1]   <= {dv_work_reg[gi][BYTES_W-DIGIT_W-1:0], digit};
            end
        end
    end

    // Round up on a nonzero remainder; any error forces zero bytes.
    always_comb begin
        if (dv_status_reg[DIV_STAGES] == ST_OK) begin
            m_bytes_next = dv_work_reg[DIV_STAGES]
                         + BYTES_W'(dv_rem_reg[DIV_STAGES] != '0);
        end else begin
            m_bytes_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= dv_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_bytes_reg  <= m_bytes_next;
            m_status_reg <= dv_status_reg[DIV_STAGES];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_bytes_reg;
    assign m_axis_tuser  = m_status_reg;

    // An error result always carries zero bytes.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero byte count");

    // The input is never held off while the output register is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A finished division moves into the output register when the pipeline advances.
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid_reg[DIV_STAGES] && advance) |=> m_axis_tvalid)
        else $error("result lost between last division stage and output");

endmodule
